// File: sv/record_wire_parser_core_macros.svh
// Assertion helpers shared by the record parser modules.
// Every check is sampled on the rising clock edge and is off while reset is high.
`ifndef RECORD_WIRE_PARSER_CORE_MACROS_SVH
`define RECORD_WIRE_PARSER_CORE_MACROS_SVH

// The condition must be true at every edge.
`define RWP_ASSERT_HOLD(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("record_wire_parser_core: invariant violated");

// When ante is true, cons must be true at the same edge.
`define RWP_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("record_wire_parser_core: implication violated");

// When ante is true, cons must be true at the next edge.
`define RWP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("record_wire_parser_core: next-cycle check violated");

`endif

// File: sv/rwp_pkg.sv
package rwp_pkg;

   localparam int unsigned FIELD_INDEX_W = 5;

   typedef enum logic [2:0] {
      KIND_SEQUENCE     = 3'd0,
      KIND_STRING_BYTE  = 3'd1,
      KIND_EMPTY_STRING = 3'd2,
      KIND_MONEY        = 3'd3,
      KIND_STATUS       = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_TRUNCATED    = 2'd1,
      ST_BAD_PRESENCE = 2'd2,
      ST_EXTRA_BYTE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [FIELD_INDEX_W-1:0] field_index;
      kind_type                 kind;
      logic [7:0]               string_byte;
      logic                     string_last;
      logic [63:0]              word_value;
      logic                     money_present;
      logic                     record_end;
      status_type               status;
   } rsp_type;

endpackage

// File: sv/rwp_parse.sv
`include "record_wire_parser_core_macros.svh"

// Field walker: holds the parse state and builds at most one result word per input byte.
module rwp_parse
   import rwp_pkg::*;
#(
   parameter int unsigned STRING_FIELDS = 8,
   parameter int unsigned MONEY_FIELDS  = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] payload_byte,
   input  logic       payload_last,
   output logic       push,
   output rsp_type    rsp
);

   localparam int unsigned TOTAL_FIELDS = STRING_FIELDS + MONEY_FIELDS;
   localparam int unsigned FC_BITS      = $clog2(TOTAL_FIELDS + 2);
   localparam int unsigned FC_W         = (FC_BITS > FIELD_INDEX_W) ? FC_BITS : FIELD_INDEX_W;
   localparam logic [FC_W-1:0] LAST_STRING = FC_W'(STRING_FIELDS);
   localparam logic [FC_W-1:0] LAST_FIELD  = FC_W'(TOTAL_FIELDS);

   typedef enum logic [1:0] {
      PH_HEAD  = 2'd0,
      PH_BODY  = 2'd1,
      PH_DONE  = 2'd2,
      PH_VALUE = 2'd3
   } phase_type;

   logic [FC_W-1:0] field_ff, field_in;
   phase_type       phase_ff, phase_in;
   logic [2:0]      byte_cnt_ff, byte_cnt_in;
   logic [63:0]     word_ff, word_in;
   logic [31:0]     remain_ff, remain_in;
   logic [7:0]      presence_ff, presence_in;
   logic            draining_ff, draining_in;

   logic [63:0]     word_new;
   logic [31:0]     remain_dec;
   logic [FC_W-1:0] field_next;
   logic [FC_W-1:0] fi;
   logic            item;
   status_type      err;
   kind_type        kind;
   logic [7:0]      sbyte;
   logic            slast;
   logic [63:0]     wval;
   logic            mpres;
   status_type      end_status;
   logic            push_c;

   assign word_new   = word_ff | ({56'd0, payload_byte} << {byte_cnt_ff, 3'b000});
   assign remain_dec = remain_ff - 32'd1;
   assign field_next = field_ff + FC_W'(1);

   always_comb begin
      field_in    = field_ff;
      phase_in    = phase_ff;
      byte_cnt_in = byte_cnt_ff;
      word_in     = word_ff;
      remain_in   = remain_ff;
      presence_in = presence_ff;
      draining_in = draining_ff;
      fi          = field_ff;
      item        = 1'b0;
      err         = ST_OK;
      kind        = KIND_STATUS;
      sbyte       = 8'd0;
      slast       = 1'b0;
      wval        = 64'd0;
      mpres       = 1'b0;
      end_status  = ST_OK;
      push_c      = 1'b0;
      rsp         = '0;

      if (draining_ff) begin
         if (payload_last) begin
            field_in    = '0;
            phase_in    = PH_HEAD;
            byte_cnt_in = 3'd0;
            word_in     = 64'd0;
            remain_in   = 32'd0;
            presence_in = 8'd0;
            draining_in = 1'b0;
         end
      end else begin
         case (phase_ff)
            PH_DONE: begin
               err = ST_EXTRA_BYTE;
               fi  = LAST_FIELD;
            end
            PH_HEAD: begin
               if (field_ff == '0) begin
                  word_in = word_new;
                  if (byte_cnt_ff == 3'd7) begin
                     item = 1'b1;
                     kind = KIND_SEQUENCE;
                     wval = word_new;
                  end else begin
                     byte_cnt_in = byte_cnt_ff + 3'd1;
                  end
               end else if (field_ff <= LAST_STRING) begin
                  word_in = word_new;
                  if (byte_cnt_ff[1:0] == 2'd3) begin
                     remain_in = word_new[31:0];
                     if (word_new[31:0] == 32'd0) begin
                        item = 1'b1;
                        kind = KIND_EMPTY_STRING;
                     end else begin
                        phase_in    = PH_BODY;
                        byte_cnt_in = 3'd0;
                        word_in     = 64'd0;
                     end
                  end else begin
                     byte_cnt_in = byte_cnt_ff + 3'd1;
                  end
               end else begin
                  presence_in = payload_byte;
                  phase_in    = PH_VALUE;
                  byte_cnt_in = 3'd0;
                  word_in     = 64'd0;
               end
            end
            PH_BODY: begin
               remain_in = remain_dec;
               item      = 1'b1;
               kind      = KIND_STRING_BYTE;
               sbyte     = payload_byte;
               slast     = (remain_dec == 32'd0);
            end
            default: begin
               word_in = word_new;
               if (byte_cnt_ff == 3'd7) begin
                  if (presence_ff > 8'd1) begin
                     err = ST_BAD_PRESENCE;
                  end else begin
                     item  = 1'b1;
                     kind  = KIND_MONEY;
                     mpres = presence_ff[0];
                     wval  = presence_ff[0] ? word_new : 64'd0;
                  end
               end else begin
                  byte_cnt_in = byte_cnt_ff + 3'd1;
               end
            end
         endcase

         // Field finished: move to the next one (sequence, empty string, last
         // string byte, money value).
         if (item && (kind != KIND_STRING_BYTE || slast)) begin
            field_in    = field_next;
            byte_cnt_in = 3'd0;
            word_in     = 64'd0;
            phase_in    = (field_next > LAST_FIELD) ? PH_DONE : PH_HEAD;
         end

         end_status = (phase_in == PH_DONE) ? ST_OK : ST_TRUNCATED;

         if (err != ST_OK) begin
            push_c          = 1'b1;
            rsp.field_index = fi[FIELD_INDEX_W-1:0];
            rsp.kind        = KIND_STATUS;
            rsp.record_end  = 1'b1;
            rsp.status      = err;
            draining_in     = !payload_last;
         end else begin
            push_c            = item || payload_last;
            rsp.field_index   = fi[FIELD_INDEX_W-1:0];
            rsp.kind          = item ? kind : KIND_STATUS;
            rsp.string_byte   = sbyte;
            rsp.string_last   = slast;
            rsp.word_value    = wval;
            rsp.money_present = mpres;
            rsp.record_end    = payload_last;
            rsp.status        = payload_last ? end_status : ST_OK;
         end

         // Record closed: start the next one afresh.
         if (err != ST_OK || payload_last) begin
            field_in    = '0;
            phase_in    = PH_HEAD;
            byte_cnt_in = 3'd0;
            word_in     = 64'd0;
            remain_in   = 32'd0;
            presence_in = 8'd0;
         end
      end
   end

   assign push = step && push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff    <= '0;
         phase_ff    <= PH_HEAD;
         byte_cnt_ff <= 3'd0;
         word_ff     <= 64'd0;
         remain_ff   <= 32'd0;
         presence_ff <= 8'd0;
         draining_ff <= 1'b0;
      end else if (step) begin
         field_ff    <= field_in;
         phase_ff    <= phase_in;
         byte_cnt_ff <= byte_cnt_in;
         word_ff     <= word_in;
         remain_ff   <= remain_in;
         presence_ff <= presence_in;
         draining_ff <= draining_in;
      end
   end

   `RWP_ASSERT_IMPL(a_drain_silent, draining_ff, !push)
   `RWP_ASSERT_NEXT(a_close_restarts, push && rsp.record_end,
                    field_ff == '0 && phase_ff == PH_HEAD)
   `RWP_ASSERT_IMPL(a_body_nonzero, phase_ff == PH_BODY, remain_ff != 32'd0)

endmodule

// File: sv/rwp_rsp_buf.sv
`include "record_wire_parser_core_macros.svh"

// Two-word result buffer; keeps taking words while one waits downstream.
module rwp_rsp_buf
   import rwp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    has_room,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_word
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_word  = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = push_word;
         end else begin
            head_in = tail_ff;
            tail_in = push_word;
         end
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_word;
         end else begin
            tail_in = push_word;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `RWP_ASSERT_IMPL(a_no_overflow, push, count_ff != 2'd2)
   `RWP_ASSERT_HOLD(a_count_range, count_ff != 2'd3)
   `RWP_ASSERT_NEXT(a_head_held, out_valid && !out_ready, $stable(head_ff))

endmodule

// File: sv/record_wire_parser_core.sv
// Streaming record parser. One payload byte is taken per req word (req_payload_last marks the
// final byte) and at most one rsp word comes out of it: the 64-bit sequence word, each string
// content byte (or one empty-string word), each money field with its 64 value bits (zero if
// absent), or a status-only word. The word that closes a record carries rsp_record_end and the
// status: ok, truncated (payload ended early), bad presence (presence byte above 1, reported
// with the last value byte) or extra byte (first byte past a complete record). After an error
// the rest of the payload is dropped silently up to and including its last byte. Every byte is
// handled in the cycle it is accepted, so the block sustains one req word per clock while the
// buffer has room; results land in a two-word output buffer, so req_ready stays high while one
// result waits on rsp_ready and drops only when both buffer slots are occupied. Results are
// registered before rsp_valid. There is no configuration and no start-up pass after reset.
module record_wire_parser_core
   import rwp_pkg::*;
#(
   parameter int unsigned STRING_FIELDS = 8,
   parameter int unsigned MONEY_FIELDS  = 10
) (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_payload_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_index,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_string_byte,
   output logic        rsp_string_last,
   output logic [63:0] rsp_word_value,
   output logic        rsp_money_present,
   output logic        rsp_record_end,
   output logic [1:0]  rsp_status
);

   logic    step;       // byte word accepted this cycle
   logic    push;       // parser produced a result word
   rsp_type parse_word; // result built from the current byte
   rsp_type out_word;   // word at the head of the output buffer
   logic    has_room;

   assign req_ready = has_room;
   assign step      = req_valid && req_ready;

   // Parse state and per-byte decode.
   rwp_parse #(
      .STRING_FIELDS (STRING_FIELDS),
      .MONEY_FIELDS  (MONEY_FIELDS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .payload_byte (req_payload_byte),
      .payload_last (req_payload_last),
      .push         (push),
      .rsp          (parse_word)
   );

   // Registered result stage with one spare slot.
   rwp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (parse_word),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_field_index   = out_word.field_index;
   assign rsp_kind          = out_word.kind;
   assign rsp_string_byte   = out_word.string_byte;
   assign rsp_string_last   = out_word.string_last;
   assign rsp_word_value    = out_word.word_value;
   assign rsp_money_present = out_word.money_present;
   assign rsp_record_end    = out_word.record_end;
   assign rsp_status        = out_word.status;

endmodule
